// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL; every check is clocked on clock and
// disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ctt_pkg.sv =====
package ctt_pkg;

   // Lexer modes, error modes last.
   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_STAR,
      MODE_WORD,
      MODE_QUOTE,
      MODE_ESC,
      MODE_ERR_MALFORMED,
      MODE_ERR_TOKEN,
      MODE_ERR_TEXT
   } lex_mode_type;

   localparam logic FUNC_TEXT = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   localparam logic [1:0] EV_CHAR      = 2'd0;
   localparam logic [1:0] EV_TOKEN_END = 2'd1;
   localparam logic [1:0] EV_DONE      = 2'd2;
   localparam logic [1:0] EV_ERROR     = 2'd3;

   localparam logic [1:0] KIND_WORD  = 2'd0;
   localparam logic [1:0] KIND_OPEN  = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;

   localparam logic [1:0] ERR_MALFORMED = 2'd0;
   localparam logic [1:0] ERR_TOKEN     = 2'd1;
   localparam logic [1:0] ERR_TEXT      = 2'd2;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;

   localparam int OFFSET_W     = 17;
   localparam int BUNDLE_ITEMS = 3;
   localparam int QUEUE_AW     = 2;
   localparam int QUEUE_DEPTH  = 4;
   localparam logic [QUEUE_AW:0] QUEUE_LEVEL_MAX = 3'd4;

   typedef struct packed {
      logic [1:0]          event_res;
      logic [7:0]          char_value;
      logic [1:0]          token_kind;
      logic [OFFSET_W-1:0] token_begin;
      logic [OFFSET_W-1:0] token_end;
      logic [1:0]          error_code;
   } rsp_item_type;

   // Results of one input item; count is 1 to 3.
   typedef struct packed {
      rsp_item_type [BUNDLE_ITEMS-1:0] items;
      logic [1:0]                      count;
   } bundle_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QUEUE_AW:0] level;
   } queue_status_type;

   function automatic rsp_item_type mk_char(input logic [7:0] ch);
      rsp_item_type r;
      r = '0;
      r.event_res  = EV_CHAR;
      r.char_value = ch;
      return r;
   endfunction

   function automatic rsp_item_type mk_end(input logic [1:0] kind,
                                           input logic [OFFSET_W-1:0] tb,
                                           input logic [OFFSET_W-1:0] te);
      rsp_item_type r;
      r = '0;
      r.event_res   = EV_TOKEN_END;
      r.token_kind  = kind;
      r.token_begin = tb;
      r.token_end   = te;
      return r;
   endfunction

   function automatic rsp_item_type mk_done();
      rsp_item_type r;
      r = '0;
      r.event_res = EV_DONE;
      return r;
   endfunction

   function automatic rsp_item_type mk_err(input logic [1:0] code);
      rsp_item_type r;
      r = '0;
      r.event_res  = EV_ERROR;
      r.error_code = code;
      return r;
   endfunction

endpackage

// ===== src/ctt_req_if.sv =====
interface ctt_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] byte_value;

   modport source (output valid, output func, output byte_value, input ready);
   modport sink (input valid, input func, input byte_value, output ready);
endinterface

// ===== src/ctt_rsp_if.sv =====
interface ctt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_res;
   logic [7:0]  char_value;
   logic [1:0]  token_kind;
   logic [16:0] token_begin;
   logic [16:0] token_end;
   logic [1:0]  error_code;
   logic        last;

   modport source (output valid, output event_res, output char_value, output token_kind,
                   output token_begin, output token_end, output error_code,
                   output last, input ready);
   modport sink (input valid, input event_res, input char_value, input token_kind,
                 input token_begin, input token_end, input error_code,
                 input last, output ready);
endinterface

// ===== src/ctt_front.sv =====
module ctt_front
   import ctt_pkg::*;
#(
   parameter int TOKEN_BYTES    = 256,
   parameter int MAX_TEXT_BYTES = 65536
) (
   input  logic             clock,
   input  logic             reset,
   ctt_req_if.sink          req,
   input  queue_status_type q_status,
   output logic             push,
   output bundle_type       push_bundle
);

   localparam int TL_W  = $clog2(TOKEN_BYTES);
   localparam int POS_W = $clog2(MAX_TEXT_BYTES + 1);
   localparam logic [TL_W-1:0]  TL_MAX  = TL_W'(TOKEN_BYTES - 1);
   localparam logic [TL_W-1:0]  TL_MAX1 = TL_W'(TOKEN_BYTES - 2);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT_BYTES);

   lex_mode_type     mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] begin_ff, begin_in;
   logic [TL_W-1:0]  tl_ff, tl_in;
   logic [7:0]       first_ff, first_in;

   logic             accept;
   logic [7:0]       ch;
   logic             ws, nl, full0, full1, pos_full, in_error;
   logic             esc_single;
   logic [7:0]       esc_char;
   logic [1:0]       word_kind;
   logic [POS_W-1:0] pos_inc;
   logic [POS_W+OFFSET_W-1:0] pos_wide, pos1_wide, beg_wide;
   logic [OFFSET_W-1:0] pos_o, pos1_o, beg_o;
   logic [1:0]       n;

   assign accept     = req.valid && !q_status.full;
   assign req.ready  = !q_status.full;
   assign ch         = req.byte_value;
   assign ws         = (ch <= CH_SPACE);
   assign nl         = (ch == CH_LF) || (ch == CH_CR);
   assign full0      = (tl_ff >= TL_MAX);
   assign full1      = (tl_ff >= TL_MAX1);
   assign pos_full   = (pos_ff >= POS_MAX);
   assign in_error   = (mode_ff == MODE_ERR_MALFORMED) || (mode_ff == MODE_ERR_TOKEN) ||
                       (mode_ff == MODE_ERR_TEXT);
   assign pos_inc    = pos_ff + POS_W'(1);
   assign pos_wide   = {{OFFSET_W{1'b0}}, pos_ff};
   assign pos1_wide  = {{OFFSET_W{1'b0}}, pos_inc};
   assign beg_wide   = {{OFFSET_W{1'b0}}, begin_ff};
   assign pos_o      = pos_wide[OFFSET_W-1:0];
   assign pos1_o     = pos1_wide[OFFSET_W-1:0];
   assign beg_o      = beg_wide[OFFSET_W-1:0];

   assign esc_single = (ch == CH_N) || (ch == CH_T) || (ch == CH_QUOTE) ||
                       (ch == CH_APOS) || (ch == CH_BSLASH);
   assign esc_char   = (ch == CH_N) ? CH_LF : ((ch == CH_T) ? CH_TAB : ch);

   always_comb begin
      word_kind = KIND_WORD;
      if (tl_ff == TL_W'(1)) begin
         if (first_ff == CH_LBRACE) begin
            word_kind = KIND_OPEN;
         end else if (first_ff == CH_RBRACE) begin
            word_kind = KIND_CLOSE;
         end
      end
   end

   // Next mode.
   always_comb begin
      mode_in = mode_ff;
      if (req.func == FUNC_END) begin
         mode_in = MODE_IDLE;
      end else if (in_error) begin
         mode_in = mode_ff;
      end else if (pos_full) begin
         mode_in = MODE_ERR_TEXT;
      end else begin
         case (mode_ff)
            MODE_IDLE: begin
               if (ws) mode_in = MODE_IDLE;
               else if (ch == CH_HASH) mode_in = MODE_LINE;
               else if (ch == CH_SLASH) mode_in = MODE_SLASH;
               else if (ch == CH_QUOTE) mode_in = MODE_QUOTE;
               else mode_in = MODE_WORD;
            end
            MODE_SLASH: begin
               if (ch == CH_SLASH) mode_in = MODE_LINE;
               else if (ch == CH_STAR) mode_in = MODE_BLOCK;
               else if (ws) mode_in = MODE_IDLE;
               else mode_in = MODE_WORD;
            end
            MODE_LINE: begin
               if (nl) mode_in = MODE_IDLE;
            end
            MODE_BLOCK: begin
               if (ch == CH_STAR) mode_in = MODE_STAR;
            end
            MODE_STAR: begin
               if (ch == CH_SLASH) mode_in = MODE_IDLE;
               else if (ch != CH_STAR) mode_in = MODE_BLOCK;
            end
            MODE_WORD: begin
               if (ws) mode_in = MODE_IDLE;
               else if (full0) mode_in = MODE_ERR_TOKEN;
            end
            MODE_QUOTE: begin
               if (ch == CH_QUOTE) mode_in = MODE_IDLE;
               else if (ch == CH_BSLASH) mode_in = MODE_ESC;
               else if (full0) mode_in = MODE_ERR_TOKEN;
            end
            MODE_ESC: begin
               if (full0 || (!esc_single && full1)) mode_in = MODE_ERR_TOKEN;
               else mode_in = MODE_QUOTE;
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   // Results and token bookkeeping.
   always_comb begin
      push_bundle = '0;
      n        = 2'd0;
      pos_in   = pos_ff;
      begin_in = begin_ff;
      tl_in    = tl_ff;
      first_in = first_ff;
      if (req.func == FUNC_END) begin
         pos_in   = '0;
         begin_in = '0;
         tl_in    = '0;
         first_in = '0;
         case (mode_ff)
            MODE_IDLE, MODE_LINE: begin
               push_bundle.items[0] = mk_done();
               n = 2'd1;
            end
            MODE_SLASH: begin
               push_bundle.items[0] = mk_char(CH_SLASH);
               push_bundle.items[1] = mk_end(KIND_WORD, beg_o, pos_o);
               push_bundle.items[2] = mk_done();
               n = 2'd3;
            end
            MODE_WORD: begin
               push_bundle.items[0] = mk_end(word_kind, beg_o, pos_o);
               push_bundle.items[1] = mk_done();
               n = 2'd2;
            end
            MODE_BLOCK, MODE_STAR, MODE_QUOTE: begin
               push_bundle.items[0] = mk_err(ERR_MALFORMED);
               n = 2'd1;
            end
            MODE_ESC: begin
               // Keep the pending backslash if it fits, then report.
               if (full0) begin
                  push_bundle.items[0] = mk_err(ERR_TOKEN);
                  n = 2'd1;
               end else begin
                  push_bundle.items[0] = mk_char(CH_BSLASH);
                  push_bundle.items[1] = mk_err(ERR_MALFORMED);
                  n = 2'd2;
               end
            end
            MODE_ERR_MALFORMED: begin
               push_bundle.items[0] = mk_err(ERR_MALFORMED);
               n = 2'd1;
            end
            MODE_ERR_TOKEN: begin
               push_bundle.items[0] = mk_err(ERR_TOKEN);
               n = 2'd1;
            end
            MODE_ERR_TEXT: begin
               push_bundle.items[0] = mk_err(ERR_TEXT);
               n = 2'd1;
            end
            default: begin
               push_bundle.items[0] = mk_done();
               n = 2'd1;
            end
         endcase
      end else if (in_error) begin
         n = 2'd0;
      end else if (pos_full) begin
         push_bundle.items[0] = mk_err(ERR_TEXT);
         n = 2'd1;
      end else begin
         pos_in = pos_inc;
         case (mode_ff)
            MODE_IDLE: begin
               if (ws || ch == CH_HASH) begin
                  n = 2'd0;
               end else if (ch == CH_SLASH) begin
                  begin_in = pos_ff;
               end else if (ch == CH_QUOTE) begin
                  begin_in = pos_ff;
                  tl_in    = '0;
               end else begin
                  begin_in = pos_ff;
                  tl_in    = TL_W'(1);
                  first_in = ch;
                  push_bundle.items[0] = mk_char(ch);
                  n = 2'd1;
               end
            end
            MODE_SLASH: begin
               if (ch != CH_SLASH && ch != CH_STAR) begin
                  push_bundle.items[0] = mk_char(CH_SLASH);
                  n = 2'd2;
                  if (ws) begin
                     push_bundle.items[1] = mk_end(KIND_WORD, beg_o, pos_o);
                     tl_in    = '0;
                     first_in = '0;
                  end else begin
                     push_bundle.items[1] = mk_char(ch);
                     tl_in    = TL_W'(2);
                     first_in = CH_SLASH;
                  end
               end
            end
            MODE_WORD: begin
               if (ws) begin
                  push_bundle.items[0] = mk_end(word_kind, beg_o, pos_o);
                  tl_in    = '0;
                  first_in = '0;
               end else if (full0) begin
                  push_bundle.items[0] = mk_err(ERR_TOKEN);
               end else begin
                  push_bundle.items[0] = mk_char(ch);
                  tl_in = tl_ff + TL_W'(1);
                  if (tl_ff == '0) first_in = ch;
               end
               n = 2'd1;
            end
            MODE_QUOTE: begin
               if (ch == CH_QUOTE) begin
                  push_bundle.items[0] = mk_end(KIND_WORD, beg_o, pos1_o);
                  tl_in    = '0;
                  first_in = '0;
                  n = 2'd1;
               end else if (ch != CH_BSLASH) begin
                  if (full0) begin
                     push_bundle.items[0] = mk_err(ERR_TOKEN);
                  end else begin
                     push_bundle.items[0] = mk_char(ch);
                     tl_in = tl_ff + TL_W'(1);
                     if (tl_ff == '0) first_in = ch;
                  end
                  n = 2'd1;
               end
            end
            MODE_ESC: begin
               if (full0) begin
                  push_bundle.items[0] = mk_err(ERR_TOKEN);
                  n = 2'd1;
               end else if (esc_single) begin
                  push_bundle.items[0] = mk_char(esc_char);
                  tl_in = tl_ff + TL_W'(1);
                  if (tl_ff == '0) first_in = esc_char;
                  n = 2'd1;
               end else begin
                  // Unknown escape: keep the backslash, then the byte.
                  push_bundle.items[0] = mk_char(CH_BSLASH);
                  if (tl_ff == '0) first_in = CH_BSLASH;
                  if (full1) begin
                     push_bundle.items[1] = mk_err(ERR_TOKEN);
                     tl_in = tl_ff + TL_W'(1);
                  end else begin
                     push_bundle.items[1] = mk_char(ch);
                     tl_in = tl_ff + TL_W'(2);
                  end
                  n = 2'd2;
               end
            end
            default: n = 2'd0;
         endcase
      end
      push_bundle.count = n;
   end

   assign push = accept && (n != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         begin_ff <= '0;
         tl_ff    <= '0;
         first_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         tl_ff    <= tl_in;
         first_ff <= first_in;
      end
   end

endmodule

// ===== src/ctt_queue.sv =====
module ctt_queue
   import ctt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bundle_type       push_bundle,
   input  logic             pop,
   output bundle_type       head_bundle,
   output queue_status_type q_status
);

   bundle_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   level_ff, level_in;
   logic                do_push, do_pop;

   assign q_status.full  = (level_ff == QUEUE_LEVEL_MAX);
   assign q_status.empty = (level_ff == '0);
   assign q_status.level = level_ff;
   assign head_bundle    = entry_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !q_status.full;
      do_pop    = pop && !q_status.empty;
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      level_in  = level_ff + (QUEUE_AW + 1)'(do_push) - (QUEUE_AW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

// ===== src/ctt_back.sv =====
module ctt_back
   import ctt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  bundle_type       head_bundle,
   input  queue_status_type q_status,
   output logic             pop,
   ctt_rsp_if.source        rsp
);

   logic         valid_ff, valid_in;
   logic [1:0]   idx_ff, idx_in;
   rsp_item_type item_ff;
   logic         last_ff;
   logic         load, take, is_last;

   always_comb begin
      load     = !valid_ff || rsp.ready;
      take     = load && !q_status.empty;
      is_last  = (idx_ff == head_bundle.count - 2'd1);
      pop      = take && is_last;
      idx_in   = take ? (is_last ? 2'd0 : idx_ff + 2'd1) : idx_ff;
      valid_in = load ? !q_status.empty : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= head_bundle.items[idx_ff];
         last_ff <= is_last;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.event_res   = item_ff.event_res;
   assign rsp.char_value  = item_ff.char_value;
   assign rsp.token_kind  = item_ff.token_kind;
   assign rsp.token_begin = item_ff.token_begin;
   assign rsp.token_end   = item_ff.token_end;
   assign rsp.error_code  = item_ff.error_code;
   assign rsp.last        = last_ff;

endmodule

// ===== src/catalog_text_tokenizer.sv =====
// Streaming tokenizer for catalog text, one byte per transaction.
// req_chan carries func (0 text byte, 1 end of text) and byte_value; rsp_chan
// returns token characters, token-end items with kind and byte offsets,
// text-done and error items, with last set on the final result of a request.
// The front lexer classifies each byte in the cycle it is accepted and writes
// all of its results (up to three) as one bundle into a four-entry queue; the
// back end drains one result per cycle into the output register while rsp_chan is not stalled.
// Path: a result passes a queue entry, then the output register on rsp_chan.
// Throughput: one request per cycle while each request yields at most one
// result and rsp_chan.ready stays high; the output port moves one result per
// cycle while ready is high, and the queue absorbs the bursts of larger bundles.
// Stall: while rsp_chan.ready is low the output register holds; bundles pile
// up in the queue and req_chan.ready drops once four are waiting.
// Reset: the lexer returns to between-tokens with no error and offsets at
// zero, the queue empties and rsp_chan.valid goes low.
// An end-of-text request flushes an open word, reports done, the sticky error or
// an error for an unclosed comment or string, and restarts the lexer.
`include "assert_macros.svh"

module catalog_text_tokenizer
   import ctt_pkg::*;
#(
   parameter int TOKEN_BYTES    = 256,
   parameter int MAX_TEXT_BYTES = 65536
) (
   input logic        clock,
   input logic        reset,
   ctt_req_if.sink    req_chan,
   ctt_rsp_if.source  rsp_chan
);

   logic             push;
   logic             pop;
   bundle_type       push_bundle;
   bundle_type       head_bundle;
   queue_status_type q_status;

   // Classify bytes and build result bundles.
   ctt_front #(
      .TOKEN_BYTES    (TOKEN_BYTES),
      .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .q_status    (q_status),
      .push        (push),
      .push_bundle (push_bundle)
   );

   // Decouple the lexer from the output side.
   ctt_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head_bundle (head_bundle),
      .q_status    (q_status)
   );

   // Serialize each bundle onto the result channel.
   ctt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_bundle (head_bundle),
      .q_status    (q_status),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

   `ASSERT_ALWAYS(a_no_overflow, !(push && q_status.full), "bundle pushed into full queue")
   `ASSERT_ALWAYS(a_no_underflow, !(pop && q_status.empty), "bundle popped from empty queue")
   `ASSERT_ALWAYS(a_level_bound, q_status.level <= QUEUE_LEVEL_MAX, "queue level out of range")
   `ASSERT_NEXT(a_push_lands, push, !q_status.empty, "pushed bundle missing from queue")

endmodule

// ===== tb/sv/tb_catalog_text_tokenizer.sv =====
module tb_catalog_text_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   import ctt_pkg::*;

   localparam int TOKEN_LIMIT   = 256;
   localparam int TEXT_LIMIT    = 65536;
   localparam int HOLD_CYCLES   = 60;
   localparam int PHASE_ITEMS   = 40;

   // One expected result: the payload plus its end-of-burst flag.
   typedef struct {
      rsp_item_type item;
      logic         last;
   } expected_result_type;

   // Scoreboard: tracks the lexer state, predicts the results of every accepted
   // transaction and matches the results that come back, oldest first.
   class token_predictor;
      lex_mode_type        mode;
      int unsigned         read_pos;
      int unsigned         tok_len;
      int unsigned         begin_off;
      logic [7:0]          first_ch;
      logic [1:0]          sticky_code;
      expected_result_type burst[$];
      expected_result_type pending_results[$];
      int unsigned         error_count;

      function new();
         restart();
         error_count = 0;
      endfunction

      function void restart();
         mode        = MODE_IDLE;
         read_pos    = 0;
         tok_len     = 0;
         begin_off   = 0;
         first_ch    = 8'h00;
         sticky_code = ERR_MALFORMED;
      endfunction

      function void push(logic [1:0] ev, logic [7:0] ch, logic [1:0] kind,
                         int unsigned b, int unsigned e, logic [1:0] code);
         expected_result_type r;
         r.item             = '0;
         r.item.event_res   = ev;
         r.item.char_value  = ch;
         r.item.token_kind  = kind;
         r.item.token_begin = OFFSET_W'(b);
         r.item.token_end   = OFFSET_W'(e);
         r.item.error_code  = code;
         r.last             = 1'b0;
         burst.push_back(r);
      endfunction

      function void raise_error(logic [1:0] code);
         sticky_code = code;
         mode        = lex_mode_type'(int'(MODE_ERR_MALFORMED) + int'(code));
         push(EV_ERROR, 8'h00, KIND_WORD, 0, 0, code);
      endfunction

      // Add one decoded character; overflow turns into the token-length error.
      function bit add_char(logic [7:0] c);
         if (tok_len + 1 >= TOKEN_LIMIT) begin
            raise_error(ERR_TOKEN);
            return 1'b0;
         end
         if (tok_len == 0) first_ch = c;
         tok_len++;
         push(EV_CHAR, c, KIND_WORD, 0, 0, ERR_MALFORMED);
         return 1'b1;
      endfunction

      function void close_token(int unsigned end_pos, bit quoted);
         logic [1:0] kind;
         kind = KIND_WORD;
         if (!quoted && tok_len == 1) begin
            if (first_ch == CH_LBRACE) kind = KIND_OPEN;
            else if (first_ch == CH_RBRACE) kind = KIND_CLOSE;
         end
         push(EV_TOKEN_END, 8'h00, kind, begin_off, end_pos, ERR_MALFORMED);
         mode     = MODE_IDLE;
         tok_len  = 0;
         first_ch = 8'h00;
      endfunction

      function void word_byte(logic [7:0] b, int unsigned pos);
         if (b <= CH_SPACE) close_token(pos, 1'b0);
         else void'(add_char(b));
      endfunction

      function void text_byte(logic [7:0] b);
         int unsigned pos;
         pos = read_pos;
         if (mode >= MODE_ERR_MALFORMED) return;
         if (pos >= TEXT_LIMIT) begin
            raise_error(ERR_TEXT);
            return;
         end
         read_pos = pos + 1;
         case (mode)
            MODE_IDLE: begin
               if (b <= CH_SPACE) begin
               end else if (b == CH_HASH) begin
                  mode = MODE_LINE;
               end else if (b == CH_SLASH) begin
                  mode      = MODE_SLASH;
                  begin_off = pos;
               end else if (b == CH_QUOTE) begin
                  mode      = MODE_QUOTE;
                  begin_off = pos;
                  tok_len   = 0;
               end else begin
                  mode      = MODE_WORD;
                  begin_off = pos;
                  tok_len   = 0;
                  void'(add_char(b));
               end
            end
            MODE_SLASH: begin
               if (b == CH_SLASH) begin
                  mode = MODE_LINE;
               end else if (b == CH_STAR) begin
                  mode = MODE_BLOCK;
               end else begin
                  mode    = MODE_WORD;
                  tok_len = 0;
                  if (add_char(CH_SLASH)) word_byte(b, pos);
               end
            end
            MODE_LINE: begin
               if (b == CH_LF || b == CH_CR) mode = MODE_IDLE;
            end
            MODE_BLOCK: begin
               if (b == CH_STAR) mode = MODE_STAR;
            end
            MODE_STAR: begin
               if (b == CH_SLASH) mode = MODE_IDLE;
               else if (b != CH_STAR) mode = MODE_BLOCK;
            end
            MODE_WORD: begin
               word_byte(b, pos);
            end
            MODE_QUOTE: begin
               if (b == CH_QUOTE) close_token(pos + 1, 1'b1);
               else if (b == CH_BSLASH) mode = MODE_ESC;
               else void'(add_char(b));
            end
            default: begin
               mode = MODE_QUOTE;
               if (b == CH_N) void'(add_char(CH_LF));
               else if (b == CH_T) void'(add_char(CH_TAB));
               else if (b == CH_QUOTE || b == CH_APOS || b == CH_BSLASH) void'(add_char(b));
               else if (add_char(CH_BSLASH)) void'(add_char(b));
            end
         endcase
      endfunction

      function void end_text();
         int unsigned pos;
         pos = read_pos;
         case (mode)
            MODE_IDLE, MODE_LINE: begin
               push(EV_DONE, 8'h00, KIND_WORD, 0, 0, ERR_MALFORMED);
            end
            MODE_SLASH: begin
               tok_len = 0;
               void'(add_char(CH_SLASH));
               close_token(pos, 1'b0);
               push(EV_DONE, 8'h00, KIND_WORD, 0, 0, ERR_MALFORMED);
            end
            MODE_WORD: begin
               close_token(pos, 1'b0);
               push(EV_DONE, 8'h00, KIND_WORD, 0, 0, ERR_MALFORMED);
            end
            MODE_BLOCK, MODE_STAR, MODE_QUOTE: begin
               raise_error(ERR_MALFORMED);
            end
            MODE_ESC: begin
               if (add_char(CH_BSLASH)) raise_error(ERR_MALFORMED);
            end
            default: begin
               push(EV_ERROR, 8'h00, KIND_WORD, 0, 0, sticky_code);
            end
         endcase
         restart();
      endfunction

      function void note_request(logic func, logic [7:0] b);
         burst.delete();
         if (func == FUNC_TEXT) text_byte(b);
         else end_text();
         if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
         foreach (burst[i]) pending_results.push_back(burst[i]);
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
         end
      endfunction

      function void check_result(rsp_item_type got, logic got_last);
         expected_result_type want;
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: event_res %0d char_value %0d",
                   got.event_res, got.char_value);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("event_res", want.item.event_res, got.event_res);
         compare_field("char_value", want.item.char_value, got.char_value);
         compare_field("token_kind", want.item.token_kind, got.token_kind);
         compare_field("token_begin", want.item.token_begin, got.token_begin);
         compare_field("token_end", want.item.token_end, got.token_end);
         compare_field("error_code", want.item.error_code, got.error_code);
         compare_field("last", want.last, got_last);
      endfunction
   endclass

   logic clock;
   logic reset;

   ctt_req_if req_chan();
   ctt_rsp_if rsp_chan();

   catalog_text_tokenizer #(
      .TOKEN_BYTES    (TOKEN_LIMIT),
      .MAX_TEXT_BYTES (TEXT_LIMIT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   token_predictor predictor = new();

   // Idling knobs, in percent, set per phase by the main sequence.
   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned accepted_count = 0;

   // Long receiver hold-off: the main sequence bumps hold_asked, the receiver
   // notices the change and counts the stretch down itself.
   int unsigned hold_asked = 0;
   int unsigned hold_seen  = 0;
   int unsigned hold_left  = 0;

   // Free-running clock, 20 ns period.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Receiver: check every completed result transaction, then pick ready for the
   // next cycle. Both handshake sides are read before the edge's updates land.
   always @(posedge clock) begin
      rsp_item_type got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got             = '0;
            got.event_res   = rsp_chan.event_res;
            got.char_value  = rsp_chan.char_value;
            got.token_kind  = rsp_chan.token_kind;
            got.token_begin = rsp_chan.token_begin;
            got.token_end   = rsp_chan.token_end;
            got.error_code  = rsp_chan.error_code;
            predictor.check_result(got, rsp_chan.last);
         end
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Offer one request transaction, with random idle cycles ahead of it, and
   // hand it to the predictor at the edge where it is taken.
   task automatic send_item(input logic func, input logic [7:0] b);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= func;
      req_chan.byte_value <= b;
      do @(posedge clock); while (!req_chan.ready);
      predictor.note_request(func, b);
      accepted_count++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(FUNC_TEXT, b);
   endtask

   // The byte travels with the end marker too; the block must ignore it.
   task automatic send_end();
      send_item(FUNC_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_space();
      int n;
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 32)));
   endtask

   // Word start: anything above space that does not open a comment or string.
   task automatic send_word_head();
      logic [7:0] b;
      do b = 8'($urandom_range(33, 255));
      while (b == CH_HASH || b == CH_SLASH || b == CH_QUOTE);
      send_byte(b);
   endtask

   task automatic send_word_body();
      int n;
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(33, 255)));
   endtask

   // Quoted string with random plain bytes and every kind of escape.
   task automatic send_quoted();
      int n;
      logic [7:0] b;
      n = $urandom_range(0, 5);
      send_byte(CH_QUOTE);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            send_byte(CH_BSLASH);
            case ($urandom_range(0, 5))
               0: send_byte(CH_N);
               1: send_byte(CH_T);
               2: send_byte(CH_QUOTE);
               3: send_byte(CH_APOS);
               4: send_byte(CH_BSLASH);
               default: send_byte(8'($urandom_range(0, 255)));
            endcase
         end else begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
            send_byte(b);
         end
      end
      send_byte(CH_QUOTE);
   endtask

   task automatic send_fragment();
      int n;
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0: send_space();
         1, 2: begin
            send_word_head();
            send_word_body();
            send_space();
         end
         3: begin
            send_byte($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
            send_space();
         end
         4, 5: send_quoted();
         6: begin
            // Line comment, from a hash or a double slash, closed by CR or LF.
            if ($urandom_range(0, 1)) begin
               send_byte(CH_HASH);
            end else begin
               send_byte(CH_SLASH);
               send_byte(CH_SLASH);
            end
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
               do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
               send_byte(b);
            end
            send_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
         end
         7: begin
            // Block comment with stars and slashes mixed into the body.
            send_byte(CH_SLASH);
            send_byte(CH_STAR);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(0, 3))
                  0: send_byte(CH_STAR);
                  1: send_byte(CH_SLASH);
                  2: send_byte(CH_SPACE);
                  default: send_byte(CH_N);
               endcase
            end
            send_byte(CH_STAR);
            send_byte(CH_SLASH);
         end
         8: begin
            // Lone slash starting a word.
            send_byte(CH_SLASH);
            do b = 8'($urandom_range(0, 255)); while (b == CH_SLASH || b == CH_STAR);
            send_byte(b);
            send_space();
         end
         default: send_byte(8'($urandom_range(0, 255)));
      endcase
   endtask

   // Random text: mostly well-formed fragments, sometimes cut off inside an
   // open construct right before the end marker.
   task automatic send_random_text();
      int n;
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) send_fragment();
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 6))
            0: begin
               send_byte(CH_QUOTE);
               send_word_body();
            end
            1: begin
               send_byte(CH_SLASH);
               send_byte(CH_STAR);
            end
            2: begin
               send_byte(CH_QUOTE);
               send_byte(CH_BSLASH);
            end
            3: send_byte(CH_SLASH);
            4: begin
               send_word_head();
               send_word_body();
            end
            5: send_byte(CH_HASH);
            default: begin
               send_byte(CH_SLASH);
               send_byte(CH_STAR);
               send_byte(CH_STAR);
            end
         endcase
      end
      send_end();
   endtask

   task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
      int unsigned start;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      start         = accepted_count;
      while (accepted_count - start < PHASE_ITEMS) send_random_text();
   endtask

   // Hard stop in case the block hangs.
   initial begin
      #40ms;
      $display("tb_catalog_text_tokenizer: done, errors");
      $finish;
   end

   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.func       <= FUNC_TEXT;
      req_chan.byte_value <= 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: skipped extremes, a word of 0xFF, both braces, a block
      // comment whose opener star does not close it, every escape inside a
      // quoted string, and an unknown escape that keeps its backslash.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_SPACE);
      send_string("{ } /***/\"\\n\\t\\\"\\\\\\q");
      send_byte(CH_BSLASH);
      send_byte(CH_APOS);
      send_byte(CH_QUOTE);
      send_end();
      // Lone slash flushed by the end marker.
      send_byte(CH_SLASH);
      send_end();
      // Backslash still pending when the text ends inside a string.
      send_byte(CH_QUOTE);
      send_byte(CH_BSLASH);
      send_end();

      // Random texts; the first phase opens with a long receiver hold-off so
      // the result queue fills and the request side backs up.
      hold_asked++;
      run_random_phase(0, 0);
      run_random_phase(45, 0);
      run_random_phase(0, 45);
      run_random_phase(29, 29);

      req_chan.valid <= 1'b0;
      while (predictor.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (predictor.error_count == 0 && predictor.pending_results.size() == 0) begin
         $display("tb_catalog_text_tokenizer: done, clean");
      end else begin
         $display("tb_catalog_text_tokenizer: done, errors");
      end
      $finish;
   end

endmodule
